### hdl/top_k_hit_count_table_defines.svh
// ----------------------------------------------------------------------------
// top_k_hit_count_table_defines.svh
// assertion macros shared by the checker of the hot block table
// ----------------------------------------------------------------------------
`ifndef TOP_K_HIT_COUNT_TABLE_DEFINES_SVH
`define TOP_K_HIT_COUNT_TABLE_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define TKHC_ASSERT_NOW(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication
`define TKHC_ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

### hdl/tkhc_pkg.sv
// ----------------------------------------------------------------------------
// tkhc_pkg
// types and constants of the ranked hot block table
// ----------------------------------------------------------------------------
package tkhc_pkg;

  localparam int TKHC_TABLE_DEPTH = 16;
  localparam int TKHC_COUNT_BITS  = 32;
  localparam int ADDR_W           = 32;
  localparam int HIT_W            = 32;
  localparam int SLOT_W           = 4;
  localparam int RANK_W           = 4;
  localparam int RSP_COUNT_W      = 32;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] block_addr;
    logic [HIT_W-1:0]  block_hits;
    logic [SLOT_W-1:0] slot_index;
  } tkhc_req_t;

  typedef struct packed {
    logic                   placed;
    logic [RANK_W-1:0]      new_rank;
    logic                   evicted_valid;
    logic [ADDR_W-1:0]      evicted_addr;
    logic                   slot_valid;
    logic [ADDR_W-1:0]      slot_addr;
    logic [RSP_COUNT_W-1:0] slot_count;
  } tkhc_rsp_t;

  // request broadcast to every cell during the sweep
  typedef struct packed {
    logic              notify;
    logic [ADDR_W-1:0] addr;
    logic [SLOT_W-1:0] slot_index;
  } tkhc_probe_t;

  // search wavefront handed from cell to cell
  typedef struct packed {
    logic                   live;
    logic                   hit;
    logic                   ins_found;
    logic                   rd_valid;
    logic [ADDR_W-1:0]      rd_addr;
    logic [RSP_COUNT_W-1:0] rd_count;
  } tkhc_tok_t;

  // table update broadcast
  typedef struct packed {
    logic              apply;
    logic [ADDR_W-1:0] addr;
  } tkhc_cmd_t;

endpackage

### hdl/tkhc_cell.sv
// ----------------------------------------------------------------------------
// tkhc_cell
// one rank slot: holds an entry, compares it against the request as the
// search wavefront passes, and on update loads the new entry or shifts down
// from its upper neighbor
module tkhc_cell
  import tkhc_pkg::*;
#(
  parameter int COUNT_BITS = TKHC_COUNT_BITS,
  parameter int IDX_BITS   = 4,
  parameter int CELL_IDX   = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tkhc_probe_t           probe,
  input  logic [COUNT_BITS-1:0] probe_cnt,
  input  tkhc_cmd_t             cmd,
  input  logic [IDX_BITS-1:0]   cmd_pos,
  input  logic [IDX_BITS-1:0]   cmd_lim,
  input  logic [COUNT_BITS-1:0] cmd_cnt,
  input  logic                  up_valid,
  input  logic [ADDR_W-1:0]     up_addr,
  input  logic [COUNT_BITS-1:0] up_count,
  output logic                  ent_valid,
  output logic [ADDR_W-1:0]     ent_addr,
  output logic [COUNT_BITS-1:0] ent_count,
  input  tkhc_tok_t             tok_in,
  input  logic [IDX_BITS-1:0]   run_in,
  input  logic [IDX_BITS-1:0]   hpos_in,
  input  logic [IDX_BITS-1:0]   hidx_in,
  input  logic [IDX_BITS-1:0]   ipos_in,
  output tkhc_tok_t             tok_out,
  output logic [IDX_BITS-1:0]   run_out,
  output logic [IDX_BITS-1:0]   hpos_out,
  output logic [IDX_BITS-1:0]   hidx_out,
  output logic [IDX_BITS-1:0]   ipos_out
);

  localparam logic [IDX_BITS-1:0] MY_IDX   = IDX_BITS'(CELL_IDX);
  localparam logic [IDX_BITS-1:0] NEXT_IDX = IDX_BITS'(CELL_IDX + 1);

  logic                qual;
  logic                match;
  logic                rd_here;
  logic                load_new;
  logic                shift_in;
  tkhc_tok_t           tok_next;
  logic [IDX_BITS-1:0] run_next;
  logic [IDX_BITS-1:0] hpos_next;
  logic [IDX_BITS-1:0] hidx_next;
  logic [IDX_BITS-1:0] ipos_next;

  // empty slot or count not above the request: insert point and bubble run
  assign qual    = !ent_valid || (ent_count <= probe_cnt);
  assign match   = ent_valid && (ent_addr == probe.addr);
  assign rd_here = (int'(probe.slot_index) == CELL_IDX);

  always_comb begin
    tok_next  = tok_in;
    hpos_next = hpos_in;
    hidx_next = hidx_in;
    ipos_next = ipos_in;
    // start of the run of qualifying slots that ends at this one
    run_next  = qual ? run_in : NEXT_IDX;
    if (probe.notify && match && !tok_in.hit) begin
      tok_next.hit = 1'b1;
      hidx_next    = MY_IDX;
      hpos_next    = run_in;
    end
    if (qual && !tok_in.ins_found) begin
      tok_next.ins_found = 1'b1;
      ipos_next          = MY_IDX;
    end
    if (rd_here && ent_valid) begin
      tok_next.rd_valid = 1'b1;
      tok_next.rd_addr  = ent_addr;
      tok_next.rd_count = RSP_COUNT_W'(ent_count);
    end
  end

  assign load_new = cmd.apply && (MY_IDX == cmd_pos);
  assign shift_in = cmd.apply && (MY_IDX > cmd_pos) && (MY_IDX <= cmd_lim);

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
      tok_out   <= '0;
    end else begin
      tok_out <= tok_next;
      if (load_new) begin
        ent_valid <= 1'b1;
      end else if (shift_in) begin
        ent_valid <= up_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    run_out  <= run_next;
    hpos_out <= hpos_next;
    hidx_out <= hidx_next;
    ipos_out <= ipos_next;
    if (load_new) begin
      ent_addr  <= cmd.addr;
      ent_count <= cmd_cnt;
    end else if (shift_in) begin
      ent_addr  <= up_addr;
      ent_count <= up_count;
    end
  end

endmodule

### hdl/top_k_hit_count_table.sv
// ----------------------------------------------------------------------------
// top_k_hit_count_table
// ranked table of the hottest code blocks, highest hit count in slot 0
// ----------------------------------------------------------------------------
// usage:
//   request channel: req_valid / req_stall / req_data. a notify request
//   (req_type 0) reports a block address and its hit count; a read request
//   (req_type 1) fetches one rank slot. response channel: rsp_valid /
//   rsp_stall / rsp_data, one response per request, in order.
//   a search wavefront walks the row of cells one slot per cycle after the
//   request is taken; the table update then happens in the same cycle
//   across all cells. a new request is taken only once the current one has
//   finished its walk down the cell row and its update: req_stall is high
//   while a request is in progress.
//   a finished response sits in the output register; the next request is
//   taken while it waits. if rsp_stall holds it, the following request
//   completes its search and then waits, without touching the table, until
//   the output register frees.
//   reset empties the table and drops any pending response.
// ----------------------------------------------------------------------------
module top_k_hit_count_table
  import tkhc_pkg::*;
#(
  parameter int TABLE_DEPTH = TKHC_TABLE_DEPTH,
  parameter int COUNT_BITS  = TKHC_COUNT_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  tkhc_req_t req_data,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output tkhc_rsp_t rsp_data
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

  typedef enum logic [1:0] {
    IDLE,
    SWEEP,
    DONE
  } state_t;

  state_t                state;
  logic                  launch;
  tkhc_probe_t           probe;
  logic [COUNT_BITS-1:0] probe_cnt;
  logic [COUNT_BITS-1:0] sat_cnt;
  tkhc_tok_t             fin;
  logic [IW-1:0]         fin_hpos;
  logic [IW-1:0]         fin_hidx;
  logic [IW-1:0]         fin_ipos;
  logic                  out_free;
  tkhc_rsp_t             rsp_next;
  tkhc_cmd_t             cmd;
  logic [IW-1:0]         cmd_pos;
  logic [IW-1:0]         cmd_lim;
  tkhc_tok_t             tok_init;

  logic                  ent_valid [TABLE_DEPTH];
  logic [ADDR_W-1:0]     ent_addr  [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] ent_count [TABLE_DEPTH];
  tkhc_tok_t             tok       [TABLE_DEPTH];
  logic [IW-1:0]         run_s     [TABLE_DEPTH];
  logic [IW-1:0]         hpos_s    [TABLE_DEPTH];
  logic [IW-1:0]         hidx_s    [TABLE_DEPTH];
  logic [IW-1:0]         ipos_s    [TABLE_DEPTH];

  // counts above the stored width pin at the top of the range
  if (COUNT_BITS >= HIT_W) begin : g_no_sat
    assign sat_cnt = COUNT_BITS'(req_data.block_hits);
  end else begin : g_sat
    assign sat_cnt = (|req_data.block_hits[HIT_W-1:COUNT_BITS]) ? '1 :
                     req_data.block_hits[COUNT_BITS-1:0];
  end

  assign req_stall = (state != IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    tok_init      = '0;
    tok_init.live = launch;
  end

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      tkhc_cell #(
        .COUNT_BITS (COUNT_BITS),
        .IDX_BITS   (IW),
        .CELL_IDX   (k)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .probe     (probe),
        .probe_cnt (probe_cnt),
        .cmd       (cmd),
        .cmd_pos   (cmd_pos),
        .cmd_lim   (cmd_lim),
        .cmd_cnt   (probe_cnt),
        .up_valid  (1'b0),
        .up_addr   ('0),
        .up_count  ('0),
        .ent_valid (ent_valid[k]),
        .ent_addr  (ent_addr[k]),
        .ent_count (ent_count[k]),
        .tok_in    (tok_init),
        .run_in    ('0),
        .hpos_in   ('0),
        .hidx_in   ('0),
        .ipos_in   ('0),
        .tok_out   (tok[k]),
        .run_out   (run_s[k]),
        .hpos_out  (hpos_s[k]),
        .hidx_out  (hidx_s[k]),
        .ipos_out  (ipos_s[k])
      );
    end else begin : g_body
      tkhc_cell #(
        .COUNT_BITS (COUNT_BITS),
        .IDX_BITS   (IW),
        .CELL_IDX   (k)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .probe     (probe),
        .probe_cnt (probe_cnt),
        .cmd       (cmd),
        .cmd_pos   (cmd_pos),
        .cmd_lim   (cmd_lim),
        .cmd_cnt   (probe_cnt),
        .up_valid  (ent_valid[k-1]),
        .up_addr   (ent_addr[k-1]),
        .up_count  (ent_count[k-1]),
        .ent_valid (ent_valid[k]),
        .ent_addr  (ent_addr[k]),
        .ent_count (ent_count[k]),
        .tok_in    (tok[k-1]),
        .run_in    (run_s[k-1]),
        .hpos_in   (hpos_s[k-1]),
        .hidx_in   (hidx_s[k-1]),
        .ipos_in   (ipos_s[k-1]),
        .tok_out   (tok[k]),
        .run_out   (run_s[k]),
        .hpos_out  (hpos_s[k]),
        .hidx_out  (hidx_s[k]),
        .ipos_out  (ipos_s[k])
      );
    end
  end

  // response and table update from the finished search
  always_comb begin
    rsp_next  = '0;
    cmd_pos   = fin_hpos;
    cmd_lim   = fin_hidx;
    cmd.addr  = probe.addr;
    if (probe.notify) begin
      if (fin.hit) begin
        rsp_next.placed   = 1'b1;
        rsp_next.new_rank = RANK_W'(fin_hpos);
      end else if (fin.ins_found) begin
        // new block: everything from the insert point down shifts one slot
        rsp_next.placed        = 1'b1;
        rsp_next.new_rank      = RANK_W'(fin_ipos);
        rsp_next.evicted_valid = ent_valid[TABLE_DEPTH-1];
        rsp_next.evicted_addr  = ent_valid[TABLE_DEPTH-1] ? ent_addr[TABLE_DEPTH-1] : '0;
        cmd_pos                = fin_ipos;
        cmd_lim                = LAST_IDX;
      end
    end else begin
      rsp_next.slot_valid = fin.rd_valid;
      rsp_next.slot_addr  = fin.rd_addr;
      rsp_next.slot_count = fin.rd_count;
    end
    cmd.apply = (state == DONE) && out_free && probe.notify && (fin.hit || fin.ins_found);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      launch    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      launch <= (state == IDLE) && req_valid;
      if ((state == DONE) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (req_valid) begin
            probe.notify     <= (req_data.req_type == 1'b0);
            probe.addr       <= req_data.block_addr;
            probe.slot_index <= req_data.slot_index;
            probe_cnt        <= sat_cnt;
            state            <= SWEEP;
          end
        end
        SWEEP: begin
          if (tok[TABLE_DEPTH-1].live) begin
            fin      <= tok[TABLE_DEPTH-1];
            fin_hpos <= hpos_s[TABLE_DEPTH-1];
            fin_hidx <= hidx_s[TABLE_DEPTH-1];
            fin_ipos <= ipos_s[TABLE_DEPTH-1];
            state    <= DONE;
          end
        end
        DONE: begin
          if (out_free) begin
            rsp_data <= rsp_next;
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/tkhc_chk.sv
// ----------------------------------------------------------------------------
// tkhc_chk
// port-level checks of the hot block table, bound to the top level
// ----------------------------------------------------------------------------
`include "top_k_hit_count_table_defines.svh"

module tkhc_chk
  import tkhc_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_stall,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input tkhc_rsp_t rsp_data
);

  // a taken request keeps the block busy for its search
  `TKHC_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall, "request taken while busy")

  `TKHC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled response changed")

  // a response carries either notify fields or read fields, never both
  `TKHC_ASSERT_NOW(a_rsp_kind, rsp_valid && rsp_data.slot_valid, !rsp_data.placed && !rsp_data.evicted_valid, "mixed response")

  // eviction only comes with a placement, and an unplaced block has rank zero
  `TKHC_ASSERT_NOW(a_evict_placed, rsp_valid && !rsp_data.placed, !rsp_data.evicted_valid && (rsp_data.new_rank == '0), "eviction without placement")

endmodule

bind top_k_hit_count_table tkhc_chk u_tkhc_chk (.*);

### tb/sv/top_k_hit_count_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// top_k_hit_count_table_tb
// self-checking bench for the ranked hot block table
// ----------------------------------------------------------------------------
// a local copy of the ranked table predicts every response. notify and read
// requests go through a valid/stall driver with random gaps, responses are
// taken under random back-pressure and checked field by field, in order.
// the request list opens with directed cases: empty reads, tie handling,
// promotion of a present block, a full table, eviction and an ignored
// notify. after that come mostly repeat hits on a small pool of hot blocks
// with a little noise.
// ----------------------------------------------------------------------------
module top_k_hit_count_table_tb;
  import tkhc_pkg::*;

  localparam logic REQ_NOTIFY = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  localparam int DEPTH       = TKHC_TABLE_DEPTH;
  localparam int RANDOM_REQS = 1000;
  localparam int HOT_BLOCKS  = 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int QUIET_FROM  = 4000;
  localparam int QUIET_TO    = 10000;

  localparam logic [HIT_W-1:0] COUNT_CAP =
    (TKHC_COUNT_BITS >= HIT_W) ? '1 : (HIT_W'(1) << TKHC_COUNT_BITS) - 1'b1;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  tkhc_req_t req_data  = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  tkhc_rsp_t rsp_data;

  tkhc_req_t hit_stream[$];
  tkhc_rsp_t table_answers[$];
  tkhc_rsp_t want_rsp;
  tkhc_rsp_t next_rsp;

  // predicted table contents
  logic             slot_live [DEPTH];
  logic [ADDR_W-1:0] slot_block [DEPTH];
  logic [HIT_W-1:0]  slot_hits [DEPTH];

  logic        req_fire = 1'b0;
  int unsigned cycle_no = 0;
  int          mismatches = 0;
  int          send_hold = 0;
  int          stall_left = 0;
  logic        quiet;

  assign quiet = (cycle_no >= QUIET_FROM) && (cycle_no < QUIET_TO);

  top_k_hit_count_table uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic tkhc_req_t make_req(logic kind, logic [ADDR_W-1:0] addr,
                                         logic [HIT_W-1:0] hits,
                                         logic [SLOT_W-1:0] slot);
    tkhc_req_t r;
    r.req_type   = kind;
    r.block_addr = addr;
    r.block_hits = hits;
    r.slot_index = slot;
    return r;
  endfunction

  // applies one request to the predicted table and returns its response
  task automatic rank_table_apply(input tkhc_req_t r, output tkhc_rsp_t a);
    int pos;
    int k;
    logic [HIT_W-1:0] hits;
    a = '0;
    hits = (r.block_hits > COUNT_CAP) ? COUNT_CAP : r.block_hits;
    if (r.req_type == REQ_READ) begin
      if (slot_live[r.slot_index]) begin
        a.slot_valid = 1'b1;
        a.slot_addr  = slot_block[r.slot_index];
        a.slot_count = slot_hits[r.slot_index];
      end
    end else begin
      pos = -1;
      for (k = 0; k < DEPTH; k++)
        if (pos < 0 && slot_live[k] && slot_block[k] == r.block_addr) pos = k;
      if (pos >= 0) begin
        // present block rises past lower or equal counts, never sinks
        while (pos > 0 && !(slot_live[pos-1] && slot_hits[pos-1] > hits)) begin
          slot_live[pos]  = slot_live[pos-1];
          slot_block[pos] = slot_block[pos-1];
          slot_hits[pos]  = slot_hits[pos-1];
          pos--;
        end
      end else begin
        for (k = 0; k < DEPTH; k++)
          if (pos < 0 && (!slot_live[k] || hits >= slot_hits[k])) pos = k;
        if (pos >= 0) begin
          if (slot_live[DEPTH-1]) begin
            a.evicted_valid = 1'b1;
            a.evicted_addr  = slot_block[DEPTH-1];
          end
          for (k = DEPTH - 1; k > pos; k--) begin
            slot_live[k]  = slot_live[k-1];
            slot_block[k] = slot_block[k-1];
            slot_hits[k]  = slot_hits[k-1];
          end
        end
      end
      if (pos >= 0) begin
        slot_live[pos]  = 1'b1;
        slot_block[pos] = r.block_addr;
        slot_hits[pos]  = hits;
        a.placed   = 1'b1;
        a.new_rank = RANK_W'(pos);
      end
    end
  endtask

  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    $display("%0t ns: %s expected %h got %h", $time, name, want, got);
    mismatches++;
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (send_hold > 0) begin
        send_hold--;
      end else if (!quiet && $urandom_range(0, 99) == 0) begin
        send_hold = $urandom_range(1, 19);
      end
      if (!req_valid || req_fire) begin
        if (hit_stream.size() != 0 && send_hold == 0) begin
          req_valid <= 1'b1;
          req_data  <= hit_stream.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response back-pressure
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 99) == 0) begin
      stall_left = $urandom_range(0, 18);
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // monitor: check responses, predict accepted requests
  always @(posedge clk) begin
    if (rst) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= req_valid && !req_stall;
      if (rsp_valid && !rsp_stall) begin
        if (table_answers.size() == 0) begin
          $display("%0t ns: response with no request outstanding, expected none got %h",
                   $time, rsp_data);
          mismatches++;
        end else begin
          want_rsp = table_answers.pop_front();
          if (rsp_data.placed !== want_rsp.placed)
            report_field("placed", 32'(want_rsp.placed), 32'(rsp_data.placed));
          if (rsp_data.new_rank !== want_rsp.new_rank)
            report_field("new_rank", 32'(want_rsp.new_rank), 32'(rsp_data.new_rank));
          if (rsp_data.evicted_valid !== want_rsp.evicted_valid)
            report_field("evicted_valid", 32'(want_rsp.evicted_valid),
                         32'(rsp_data.evicted_valid));
          if (rsp_data.evicted_addr !== want_rsp.evicted_addr)
            report_field("evicted_addr", want_rsp.evicted_addr, rsp_data.evicted_addr);
          if (rsp_data.slot_valid !== want_rsp.slot_valid)
            report_field("slot_valid", 32'(want_rsp.slot_valid), 32'(rsp_data.slot_valid));
          if (rsp_data.slot_addr !== want_rsp.slot_addr)
            report_field("slot_addr", want_rsp.slot_addr, rsp_data.slot_addr);
          if (rsp_data.slot_count !== want_rsp.slot_count)
            report_field("slot_count", want_rsp.slot_count, rsp_data.slot_count);
        end
      end
      if (req_valid && !req_stall) begin
        rank_table_apply(req_data, next_rsp);
        table_answers.push_back(next_rsp);
      end
    end
  end

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    logic [ADDR_W-1:0] hot_addr [HOT_BLOCKS];
    logic [HIT_W-1:0]  hot_hits [HOT_BLOCKS];
    int i;
    int k;
    int roll;

    for (k = 0; k < DEPTH; k++) begin
      slot_live[k]  = 1'b0;
      slot_block[k] = '0;
      slot_hits[k]  = '0;
    end

    // empty table reads
    hit_stream.push_back(make_req(REQ_READ, '1, '1, 4'h0));
    hit_stream.push_back(make_req(REQ_READ, '0, '0, 4'hf));
    // extremes, then a tie that the newcomer wins
    hit_stream.push_back(make_req(REQ_NOTIFY, 32'h0, 32'h0, 4'h0));
    hit_stream.push_back(make_req(REQ_NOTIFY, 32'hffff_ffff, 32'hffff_ffff, 4'hf));
    hit_stream.push_back(make_req(REQ_NOTIFY, 32'h0000_00a1, 32'h0, 4'h5));
    // present block promoted, then lowered in place
    hit_stream.push_back(make_req(REQ_NOTIFY, 32'h0, 32'd5, 4'ha));
    hit_stream.push_back(make_req(REQ_NOTIFY, 32'h0, 32'd2, 4'h3));
    // fill the table with equal counts
    for (k = 0; k < 13; k++)
      hit_stream.push_back(make_req(REQ_NOTIFY, 32'h100 + k, 32'd10, 4'(k)));
    // full table: evict the bottom entry, then a count too low to place
    hit_stream.push_back(make_req(REQ_NOTIFY, 32'h0000_0bad, 32'd1, 4'h0));
    hit_stream.push_back(make_req(REQ_NOTIFY, 32'h0000_0c01, 32'd0, 4'h0));
    // repeat hit on the lowest of a run of ties climbs to the top of the run
    hit_stream.push_back(make_req(REQ_NOTIFY, 32'h100, 32'd10, 4'h0));
    hit_stream.push_back(make_req(REQ_READ, 32'h5555_5555, 32'haaaa_aaaa, 4'h1));
    hit_stream.push_back(make_req(REQ_READ, 32'haaaa_aaaa, 32'h5555_5555, 4'hf));

    for (k = 0; k < HOT_BLOCKS; k++) begin
      hot_addr[k] = $urandom;
      hot_hits[k] = $urandom_range(0, 20);
    end
    for (i = 0; i < RANDOM_REQS; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
        hit_stream.push_back(make_req(REQ_READ, $urandom, $urandom,
                                      $urandom_range(0, 15)));
      end else if (roll < 88) begin
        k = $urandom_range(0, HOT_BLOCKS - 1);
        if ($urandom_range(0, 9) == 0)
          hot_hits[k] = $urandom_range(0, hot_hits[k]);
        else
          hot_hits[k] = hot_hits[k] + $urandom_range(0, 3);
        hit_stream.push_back(make_req(REQ_NOTIFY, hot_addr[k], hot_hits[k],
                                      $urandom_range(0, 15)));
      end else begin
        // stray blocks; full-range counts only near the end so they do not
        // lock the hot pool out of the table for the whole run
        hit_stream.push_back(make_req(REQ_NOTIFY, $urandom,
                                      (i >= RANDOM_REQS - 60) ? $urandom
                                                              : $urandom_range(0, 60),
                                      $urandom_range(0, 15)));
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (hit_stream.size() != 0 || req_valid || table_answers.size() != 0)
      @(negedge clk);
    repeat (DEPTH + 5) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
